[rtl/ppfs_pkg.sv]
// Package with the shared types and constants of the parallel port frame sender.
package ppfs_pkg;

    localparam logic [7:0] SEND_COMMAND = 8'h11;

    localparam logic [19:0] TIMEOUT_RESET = 20'd100000;
    localparam logic [15:0] MAX_SIZE_RESET = 16'd1514;

    localparam int ADDR_BITS = 3;

    typedef enum logic [0:0] {
        REG_TIMEOUT_POLLS  = 1'b0,
        REG_MAX_FRAME_SIZE = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_BUSY    = 2'd0,
        ST_SENT    = 2'd1,
        ST_BADLEN  = 2'd2,
        ST_TIMEOUT = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        PH_IDLE        = 4'b0001,
        PH_WAIT_LOW    = 4'b0010,
        PH_WAIT_TOGGLE = 4'b0100,
        PH_WAIT_FINAL  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] port_data;
        logic       port_drive;
        logic       request;
        logic       select;
        logic       byte_taken;
        logic       done_res;
        status_t    status;
    } result_t;

endpackage

[rtl/parallel_port_frame_sender_core.sv]
// Parallel port frame sender with a toggle handshake, an APB register port and a result buffer.
//
// Each input word is either a start request carrying the frame size or one poll tick
// carrying the sampled acknowledge level, and each input word yields exactly one result
// word. The word is handled in the cycle it is accepted and its result is registered into
// the output register, or into the second entry while the output side stalls, so the block
// takes one word per clock cycle while in_stall is low. A second output entry holds a
// result; input stall rises only when both entries are full. Every acknowledge wait is
// bounded by timeout_polls poll ticks (0 acts as 1), counted in a POLL_COUNT_BITS wide
// saturating counter. Registers: timeout_polls at address 0 and max_frame_size at address 4.
module parallel_port_frame_sender_core #(
    parameter int POLL_COUNT_BITS = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ppfs_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic [15:0]                   frame_size,
    input  logic                          ack_level,
    input  logic [7:0]                    next_byte,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    port_data,
    output logic                          port_drive,
    output logic                          request,
    output logic                          select,
    output logic                          byte_taken,
    output logic                          done_res,
    output logic [1:0]                    status
);

    localparam int CMP_W = ((POLL_COUNT_BITS > 20) ? POLL_COUNT_BITS : 20) + 1;

    logic [19:0]                 timeout_polls_reg;
    logic [15:0]                 max_frame_size_reg;

    ppfs_pkg::phase_t            phase_reg, phase_next;
    logic                        last_ack_reg, last_ack_next;
    logic                        request_level_reg, request_level_next;
    logic [16:0]                 bytes_left_reg, bytes_left_next;
    logic [15:0]                 size_hold_reg, size_hold_next;
    logic [POLL_COUNT_BITS-1:0]  poll_count_reg, poll_count_next;
    logic [7:0]                  bus_byte_reg, bus_byte_next;

    logic                        out_valid_reg;
    logic                        skid_valid_reg;
    ppfs_pkg::result_t           out_data_reg;
    ppfs_pkg::result_t           skid_data_reg;
    ppfs_pkg::result_t           res;

    logic                        accept;
    logic                        out_fire;
    logic                        out_free;
    logic                        cfg_write;
    ppfs_pkg::reg_index_t        cfg_index;

    logic [CMP_W-1:0]            limit_ext;
    logic [CMP_W-1:0]            count_plus;
    logic                        poll_fail;
    logic [POLL_COUNT_BITS-1:0]  poll_count_sat;
    logic [16:0]                 size_plus_two;
    logic [16:0]                 size_plus_one;
    logic [16:0]                 bytes_dec;
    logic                        sending;
    logic                        taken;
    logic                        done;
    ppfs_pkg::status_t           st;

    // Register port.
    assign pready    = 1'b1;
    assign cfg_index = ppfs_pkg::reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (cfg_index)
            ppfs_pkg::REG_TIMEOUT_POLLS:  prdata = {12'd0, timeout_polls_reg};
            ppfs_pkg::REG_MAX_FRAME_SIZE: prdata = {16'd0, max_frame_size_reg};
            default:                      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_polls_reg  <= ppfs_pkg::TIMEOUT_RESET;
            max_frame_size_reg <= ppfs_pkg::MAX_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ppfs_pkg::REG_TIMEOUT_POLLS:  timeout_polls_reg  <= pwdata[19:0];
                ppfs_pkg::REG_MAX_FRAME_SIZE: max_frame_size_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Handshake and output buffering.
    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;
    assign out_free = out_fire || !out_valid_reg;

    // Timeout check for one failed poll.
    assign limit_ext      = (timeout_polls_reg == 20'd0) ? CMP_W'(1)
                                                         : CMP_W'(timeout_polls_reg);
    assign count_plus     = CMP_W'(poll_count_reg) + CMP_W'(1);
    assign poll_fail      = (count_plus >= limit_ext);
    assign poll_count_sat = (poll_count_reg == {POLL_COUNT_BITS{1'b1}})
                            ? poll_count_reg : poll_count_reg + POLL_COUNT_BITS'(1);

    assign size_plus_two = {1'b0, size_hold_reg} + 17'd2;
    assign size_plus_one = {1'b0, size_hold_reg} + 17'd1;
    assign bytes_dec     = (bytes_left_reg != 17'd0) ? bytes_left_reg - 17'd1
                                                     : bytes_left_reg;

    always_comb
    begin
        phase_next         = phase_reg;
        last_ack_next      = last_ack_reg;
        request_level_next = request_level_reg;
        bytes_left_next    = bytes_left_reg;
        size_hold_next     = size_hold_reg;
        poll_count_next    = poll_count_reg;
        bus_byte_next      = bus_byte_reg;
        taken              = 1'b0;
        done               = 1'b0;
        st                 = ppfs_pkg::ST_BUSY;

        unique case (phase_reg)
            ppfs_pkg::PH_IDLE:
            begin
                if (!kind)
                begin
                    if (frame_size == 16'd0 || frame_size > max_frame_size_reg)
                    begin
                        done = 1'b1;
                        st   = ppfs_pkg::ST_BADLEN;
                    end
                    else
                    begin
                        size_hold_next  = frame_size;
                        bytes_left_next = {1'b0, frame_size} + 17'd2;
                        poll_count_next = '0;
                        phase_next      = ppfs_pkg::PH_WAIT_LOW;
                    end
                end
            end
            ppfs_pkg::PH_WAIT_LOW:
            begin
                if (kind)
                begin
                    if (!ack_level)
                    begin
                        last_ack_next      = 1'b0;
                        bus_byte_next      = ppfs_pkg::SEND_COMMAND;
                        request_level_next = 1'b0;
                        poll_count_next    = '0;
                        phase_next         = ppfs_pkg::PH_WAIT_TOGGLE;
                    end
                    else if (poll_fail)
                    begin
                        phase_next         = ppfs_pkg::PH_IDLE;
                        request_level_next = 1'b0;
                        bytes_left_next    = '0;
                        poll_count_next    = '0;
                        done               = 1'b1;
                        st                 = ppfs_pkg::ST_TIMEOUT;
                    end
                    else
                    begin
                        poll_count_next = poll_count_sat;
                    end
                end
            end
            ppfs_pkg::PH_WAIT_TOGGLE:
            begin
                if (kind)
                begin
                    if (ack_level != last_ack_reg)
                    begin
                        last_ack_next = ack_level;
                        if (bytes_left_reg == size_plus_two)
                        begin
                            bus_byte_next = size_hold_reg[15:8];
                        end
                        else if (bytes_left_reg == size_plus_one)
                        begin
                            bus_byte_next = size_hold_reg[7:0];
                        end
                        else
                        begin
                            bus_byte_next = next_byte;
                            taken         = 1'b1;
                        end
                        request_level_next = !request_level_reg;
                        poll_count_next    = '0;
                        bytes_left_next    = bytes_dec;
                        if (bytes_dec == 17'd0)
                        begin
                            phase_next = ppfs_pkg::PH_WAIT_FINAL;
                        end
                    end
                    else if (poll_fail)
                    begin
                        phase_next         = ppfs_pkg::PH_IDLE;
                        request_level_next = 1'b0;
                        bytes_left_next    = '0;
                        poll_count_next    = '0;
                        done               = 1'b1;
                        st                 = ppfs_pkg::ST_TIMEOUT;
                    end
                    else
                    begin
                        poll_count_next = poll_count_sat;
                    end
                end
            end
            ppfs_pkg::PH_WAIT_FINAL:
            begin
                if (kind)
                begin
                    if (ack_level != last_ack_reg || poll_fail)
                    begin
                        if (ack_level != last_ack_reg)
                        begin
                            last_ack_next = ack_level;
                            st            = ppfs_pkg::ST_SENT;
                        end
                        else
                        begin
                            st = ppfs_pkg::ST_TIMEOUT;
                        end
                        phase_next         = ppfs_pkg::PH_IDLE;
                        request_level_next = 1'b0;
                        bytes_left_next    = '0;
                        poll_count_next    = '0;
                        done               = 1'b1;
                    end
                    else
                    begin
                        poll_count_next = poll_count_sat;
                    end
                end
            end
            default:
            begin
                phase_next = ppfs_pkg::PH_IDLE;
            end
        endcase
    end

    assign sending = (phase_next == ppfs_pkg::PH_WAIT_TOGGLE)
                  || (phase_next == ppfs_pkg::PH_WAIT_FINAL);

    always_comb
    begin
        res.port_data  = bus_byte_next;
        res.port_drive = sending;
        res.request    = sending && request_level_next;
        res.select     = sending;
        res.byte_taken = taken;
        res.done_res   = done;
        res.status     = st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= ppfs_pkg::PH_IDLE;
            last_ack_reg      <= 1'b0;
            request_level_reg <= 1'b0;
            bytes_left_reg    <= '0;
            size_hold_reg     <= '0;
            poll_count_reg    <= '0;
            bus_byte_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            last_ack_reg      <= last_ack_next;
            request_level_reg <= request_level_next;
            bytes_left_reg    <= bytes_left_next;
            size_hold_reg     <= size_hold_next;
            poll_count_reg    <= poll_count_next;
            bus_byte_reg      <= bus_byte_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (accept)
            begin
                out_data_reg <= res;
            end
        end
        else if (accept)
        begin
            skid_data_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign port_data  = out_data_reg.port_data;
    assign port_drive = out_data_reg.port_drive;
    assign request    = out_data_reg.request;
    assign select     = out_data_reg.select;
    assign byte_taken = out_data_reg.byte_taken;
    assign done_res   = out_data_reg.done_res;
    assign status     = out_data_reg.status;

    // The second entry is only ever filled behind a full output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid entry holds a word while the output register is empty.");

    // A word that ends a frame attempt leaves the sender idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res.done_res) |=> (phase_reg == ppfs_pkg::PH_IDLE))
        else $error("Frame attempt ended but the sender is not idle.");

    // A consumed frame byte always comes with a request toggle.
    a_taken_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res.byte_taken) |=> (request_level_reg != $past(request_level_reg)))
        else $error("Frame byte taken without a request toggle.");

    // A final status is reported exactly on the word that ends the attempt.
    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_data_reg.status != ppfs_pkg::ST_BUSY) == out_data_reg.done_res))
        else $error("Status and done flag disagree.");

endmodule
